/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted byte key table.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SBKT_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define SBKT_ASSERT_NEVER(name, clk, rstn, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SBKT_ASSERT(name, clk, rstn, prop, msg)
`define SBKT_ASSERT_NEVER(name, clk, rstn, expr, msg)
`endif
`endif

/* sv/sbkt16_pkg.sv */
// Types and constants of the sorted byte key table.
// No dependencies.
`default_nettype none
package sbkt16_pkg;

	localparam int KEY_W         = 8;
	localparam int CMD_W         = 2;
	localparam int PORT_REF_W    = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_TOTAL_W = 5;

	typedef enum logic [CMD_W-1:0] {
		OP_LOOKUP  = 2'd0,
		OP_INSERT  = 2'd1,
		OP_REPLACE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic             ins;
		logic             rep;
		logic [KEY_W-1:0] key;
	} ctl_t;

	// Handed from one cell to its right-hand neighbour.
	typedef struct packed {
		logic             valid;
		logic             lt;
		logic             eq;
		logic [KEY_W-1:0] key;
	} link_t;

endpackage
`default_nettype wire

/* sv/sbkt16_if.sv */
// Request and response channels of the sorted byte key table.
// Depends on sbkt16_pkg for field widths.
`default_nettype none
interface sbkt16_req_if;
	logic                               valid;
	logic                               ready;
	logic [sbkt16_pkg::CMD_W-1:0]       cmd;
	logic [sbkt16_pkg::KEY_W-1:0]       search_key;
	logic [sbkt16_pkg::PORT_REF_W-1:0]  child_ref;

	modport source (output valid, cmd, search_key, child_ref, input ready);
	modport sink (input valid, cmd, search_key, child_ref, output ready);
endinterface

interface sbkt16_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  found;
	logic [sbkt16_pkg::PORT_REF_W-1:0]     found_ref;
	logic [sbkt16_pkg::STATUS_W-1:0]       status;
	logic [sbkt16_pkg::ENTRY_TOTAL_W-1:0]  entry_total;

	modport source (output valid, found, found_ref, status, entry_total, input ready);
	modport sink (input valid, found, found_ref, status, entry_total, output ready);
endinterface
`default_nettype wire

/* sv/sbkt16_cell.sv */
// One slot of the sorted table: key, reference and valid bit.
// Depends on sbkt16_pkg; instanced in a row by sorted_byte_key_table16.
`default_nettype none
module sbkt16_cell #(
	parameter int REF_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sbkt16_pkg::ctl_t      ctl,
	input  wire logic [REF_WIDTH-1:0]  new_ref,
	input  wire sbkt16_pkg::link_t     left,
	input  wire logic [REF_WIDTH-1:0]  left_ref,
	output sbkt16_pkg::link_t          right,
	output logic [REF_WIDTH-1:0]       right_ref,
	output logic                       hit,
	output logic [REF_WIDTH-1:0]       hit_ref
);

	logic                         valid_q, valid_d;
	logic [sbkt16_pkg::KEY_W-1:0] key_q, key_d;
	logic [REF_WIDTH-1:0]         ref_q, ref_d;
	logic                         lt, eq;

	assign lt = valid_q && (key_q < ctl.key);
	assign eq = valid_q && (key_q == ctl.key);
	// Equal keys sit together, so the first match has no match on its left.
	assign hit     = eq && !left.eq;
	assign hit_ref = hit ? ref_q : '0;

	assign right     = '{valid: valid_q, lt: lt, eq: eq, key: key_q};
	assign right_ref = ref_q;

	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		ref_d   = ref_q;
		if (ctl.ins && !lt) begin
			if (left.lt) begin
				// insertion point: take the new entry
				valid_d = 1'b1;
				key_d   = ctl.key;
				ref_d   = new_ref;
			end else begin
				// past the insertion point: shift up from the left
				valid_d = left.valid;
				key_d   = left.key;
				ref_d   = left_ref;
			end
		end else if (ctl.rep && hit) begin
			ref_d = new_ref;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		ref_q <= ref_d;
	end

endmodule
`default_nettype wire

/* sv/sorted_byte_key_table16.sv */
// Top level of the sorted byte key table: a row of sbkt16_cell slots.
// Depends on sbkt16_pkg, sbkt16_if.sv, sbkt16_cell.sv and assert_macros.svh.
//
//  channel  dir  fields                                   handshake
//  req      in   cmd, search_key, child_ref               valid/ready
//  rsp      out  found, found_ref, status, entry_total    valid/ready
//
// On acceptance the key is broadcast to every cell, each cell compares against
// its own entry and loads, keeps or takes its left neighbour's entry at the
// accepting edge. The response appears in the output register the cycle after
// acceptance; one request per cycle is sustained while rsp keeps being taken,
// bounded by the single compare-and-shift pass along the cell row.
// Reset clears the valid bits and the entry count; no clearing pass is needed.
// A held response stalls req only when rsp is not taken in the same cycle.
`default_nettype none
`include "assert_macros.svh"
module sorted_byte_key_table16 #(
	parameter int CAPACITY  = 16,
	parameter int REF_WIDTH = 32
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sbkt16_req_if.sink   req,
	sbkt16_rsp_if.source rsp
);

	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int PORT_W  = sbkt16_pkg::PORT_REF_W;
	localparam int TOT_W   = sbkt16_pkg::ENTRY_TOTAL_W;
	localparam int REF_CPY = (REF_WIDTH < PORT_W) ? REF_WIDTH : PORT_W;
	localparam int TOT_CPY = (CNT_W < TOT_W) ? CNT_W : TOT_W;

	logic                   accept;
	logic                   full;
	logic                   is_lookup, is_insert, is_replace;
	logic                   ins_go;
	logic [CNT_W-1:0]       count_q, count_next;
	logic [REF_WIDTH-1:0]   ref_in;
	sbkt16_pkg::ctl_t       ctl;

	sbkt16_pkg::link_t      link   [CAPACITY+1];
	logic [REF_WIDTH-1:0]   link_ref [CAPACITY+1];
	logic [CAPACITY-1:0]    cell_hit;
	logic [REF_WIDTH-1:0]   cell_hit_ref [CAPACITY];
	logic                   any_hit;
	logic [REF_WIDTH-1:0]   hit_ref_or;

	logic                   rsp_valid_q;
	logic                   found_q;
	logic [PORT_W-1:0]      found_ref_q;
	sbkt16_pkg::status_t    status_q;
	logic [TOT_W-1:0]       total_q;
	logic                   found_d;
	logic [PORT_W-1:0]      found_ref_d;
	sbkt16_pkg::status_t    status_d;
	logic [TOT_W-1:0]       total_d;

	// Take a new request whenever the output register is free or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		is_lookup  = 1'b0;
		is_insert  = 1'b0;
		is_replace = 1'b0;
		case (req.cmd)
			sbkt16_pkg::OP_LOOKUP:  is_lookup  = 1'b1;
			sbkt16_pkg::OP_INSERT:  is_insert  = 1'b1;
			sbkt16_pkg::OP_REPLACE: is_replace = 1'b1;
			default: ;  // unused code: no operation
		endcase
	end

	// Keep the low reference bits the storage can hold.
	always_comb begin
		ref_in = '0;
		ref_in[REF_CPY-1:0] = req.child_ref[REF_CPY-1:0];
	end

	// A full table drops the insert and leaves every cell untouched.
	assign ins_go = accept && is_insert && !full;
	assign ctl    = '{ins: ins_go, rep: accept && is_replace, key: req.search_key};

	// Left edge of the row: everything is "less" than the new key, nothing equal.
	assign link[0]     = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, key: '0};
	assign link_ref[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sbkt16_cell #(
			.REF_WIDTH (REF_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_ref   (ref_in),
			.left      (link[i]),
			.left_ref  (link_ref[i]),
			.right     (link[i+1]),
			.right_ref (link_ref[i+1]),
			.hit       (cell_hit[i]),
			.hit_ref   (cell_hit_ref[i])
		);
	end

	// At most one cell reports a first match, so a plain OR gathers it.
	always_comb begin
		any_hit    = 1'b0;
		hit_ref_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_hit    = any_hit | cell_hit[i];
			hit_ref_or = hit_ref_or | cell_hit_ref[i];
		end
	end

	assign count_next = count_q + CNT_W'(ins_go);

	always_comb begin
		found_d     = (is_lookup || is_replace) && any_hit;
		found_ref_d = '0;
		if (is_lookup && any_hit) begin
			found_ref_d[REF_CPY-1:0] = hit_ref_or[REF_CPY-1:0];
		end
		status_d = sbkt16_pkg::ST_OK;
		if (is_insert && full) begin
			status_d = sbkt16_pkg::ST_FULL;
		end else if (is_replace && !any_hit) begin
			status_d = sbkt16_pkg::ST_ABSENT;
		end
		total_d = '0;
		total_d[TOT_CPY-1:0] = count_next[TOT_CPY-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q     <= found_d;
			found_ref_q <= found_ref_d;
			status_q    <= status_d;
			total_q     <= total_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.found_ref   = found_ref_q;
	assign rsp.status      = status_q;
	assign rsp.entry_total = total_q;

	// Checks on the cell row and the count.
	logic [CAPACITY-1:0] cell_valid;
	logic                row_sorted;
	logic                count_ok;
	logic [CNT_W-1:0]    count_inc;
	logic                stuck_take;

	always_comb begin
		row_sorted = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			cell_valid[i] = link[i+1].valid;
		end
		for (int i = 1; i < CAPACITY; i++) begin
			if (link[i+1].valid && (link[i].key > link[i+1].key)) begin
				row_sorted = 1'b0;
			end
		end
		// valid bits form a prefix as long as the entry count
		count_ok = ($countones(cell_valid) == int'(count_q))
			&& ((cell_valid & (cell_valid + 1'b1)) == '0);
	end

	assign count_inc  = count_q + 1'b1;
	assign stuck_take = rsp_valid_q && !rsp.ready && req.ready;

	`SBKT_ASSERT(a_valid_matches_count, clk, arst_n, count_ok, "valid bits disagree with count")
	`SBKT_ASSERT(a_insert_counts, clk, arst_n, ins_go |=> count_q == $past(count_inc), "insert lost")
	`SBKT_ASSERT_NEVER(a_row_unsorted, clk, arst_n, !row_sorted, "keys out of order")
	`SBKT_ASSERT_NEVER(a_overwrite_rsp, clk, arst_n, stuck_take, "held response overwritten")

endmodule
`default_nettype wire
